// ===== src/mcc_pkg.sv =====
package mcc_pkg;

	// Sizes of the vector store and of the sample fields
	localparam int DEPTH        = 1024;
	localparam int SAMPLE_WIDTH = 16;
	localparam int ADDR_W       = $clog2(DEPTH);
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int ENTRY_W      = 2 * SAMPLE_WIDTH + 2;

	// Arithmetic widths
	localparam int SUM_W   = SAMPLE_WIDTH + CNT_W;
	localparam int NUM_W   = SUM_W + 1;
	localparam int MEAN_W  = SAMPLE_WIDTH + 1;
	localparam int DIFF_W  = MEAN_W + 1;
	localparam int PRODS_W = 2 * DIFF_W;
	localparam int ACC_W   = PRODS_W + CNT_W;
	localparam int PROD_W  = 2 * ACC_W;
	localparam int CORR_W  = 16;
	localparam int Q_W     = CORR_W;
	localparam int QB_W    = $clog2(Q_W);
	localparam int FRAC_SHIFT = 2 * (CORR_W - 1);
	localparam int QD_W    = PROD_W + Q_W;
	localparam int ROOT_W  = PROD_W + 2 * Q_W + 2;

	// Stream packing
	localparam int S_TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int M_TDATA_W = ((CORR_W + CNT_W + 7) / 8) * 8;

	// Sequencer step counts
	localparam int DIV_STEPS = NUM_W;
	localparam int MUL_STEPS = ACC_W;
	localparam int MAX_STEP  = (MUL_STEPS + 1 > DIV_STEPS + 1) ?
		((MUL_STEPS + 1 > 2 * Q_W) ? MUL_STEPS + 1 : 2 * Q_W) :
		((DIV_STEPS + 1 > 2 * Q_W) ? DIV_STEPS + 1 : 2 * Q_W);
	localparam int STEP_W    = $clog2(MAX_STEP + 1);

	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS + 1);
	localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(MUL_STEPS + 1);
	localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(2 * Q_W - 1);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_DIV_X,
		ST_DIV_Y,
		ST_WALK,
		ST_CHECK,
		ST_MUL_D,
		ST_MUL_N,
		ST_ROOT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic            load;
		logic            div_init;
		logic            div_step;
		logic            div_save;
		logic            div_sel;
		logic            walk_init;
		logic            walk_run;
		logic            mul_init;
		logic            mul_step;
		logic            mul_save;
		logic            mul_sel;
		logic            root_term;
		logic            root_cmp;
		logic [QB_W-1:0] root_bit;
		logic            out_load;
	} cmd_t;

	typedef struct packed {
		logic walk_done;
		logic special;
		logic out_free;
	} sts_t;

endpackage

// ===== src/mcc_ram.sv =====
module mcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/mcc_ctrl.sv =====
module mcc_ctrl
	import mcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	// Hold state and phase step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		step_d  = step_q + STEP_W'(1);
		case (state_q)
			ST_LOAD: begin
				step_d = '0;
				if (in_valid && in_last) state_d = ST_DIV_X;
			end
			ST_DIV_X: begin
				if (step_q == DIV_LAST) begin
					state_d = ST_DIV_Y;
					step_d  = '0;
				end
			end
			ST_DIV_Y: begin
				if (step_q == DIV_LAST) begin
					state_d = ST_WALK;
					step_d  = '0;
				end
			end
			ST_WALK: begin
				// stay on the running step until the pipe drains
				step_d = STEP_W'(1);
				if (step_q != '0 && sts.walk_done) begin
					state_d = ST_CHECK;
					step_d  = '0;
				end
			end
			ST_CHECK: begin
				step_d  = '0;
				state_d = sts.special ? ST_FINISH : ST_MUL_D;
			end
			ST_MUL_D: begin
				if (step_q == MUL_LAST) begin
					state_d = ST_MUL_N;
					step_d  = '0;
				end
			end
			ST_MUL_N: begin
				if (step_q == MUL_LAST) begin
					state_d = ST_ROOT;
					step_d  = '0;
				end
			end
			ST_ROOT: begin
				if (step_q == ROOT_LAST) begin
					state_d = ST_FINISH;
					step_d  = '0;
				end
			end
			ST_FINISH: begin
				step_d = '0;
				if (sts.out_free) state_d = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
				step_d  = '0;
			end
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV_X, ST_DIV_Y: begin
				cmd.div_sel  = (state_q == ST_DIV_Y);
				cmd.div_init = (step_q == '0);
				cmd.div_step = (step_q != '0) && (step_q != DIV_LAST);
				cmd.div_save = (step_q == DIV_LAST);
			end
			ST_WALK: begin
				cmd.walk_init = (step_q == '0);
				cmd.walk_run  = (step_q != '0);
			end
			ST_MUL_D, ST_MUL_N: begin
				cmd.mul_sel  = (state_q == ST_MUL_N);
				cmd.mul_init = (step_q == '0);
				cmd.mul_step = (step_q != '0) && (step_q != MUL_LAST);
				cmd.mul_save = (step_q == MUL_LAST);
			end
			ST_ROOT: begin
				cmd.root_term = !step_q[0];
				cmd.root_cmp  = step_q[0];
				cmd.root_bit  = QB_W'(Q_W - 1) - step_q[QB_W:1];
			end
			ST_FINISH: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && !sts.special) |=> (state_q == ST_MUL_D && step_q == '0))
		else $error("check did not start the multiply");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == ST_LOAD))
		else $error("result load did not return to loading");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.div_step, cmd.walk_run, cmd.mul_step, cmd.root_cmp,
			cmd.out_load}))
		else $error("overlapping datapath commands");

endmodule

// ===== src/mcc_dp.sv =====
module mcc_dp
	import mcc_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmd_t                           cmd,
	output sts_t                           sts,
	input  logic signed [SAMPLE_WIDTH-1:0] x_sample,
	input  logic                           x_missing,
	input  logic signed [SAMPLE_WIDTH-1:0] y_sample,
	input  logic                           y_missing,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic signed [CORR_W-1:0]       correlation,
	output logic [CNT_W-1:0]               pair_count,
	output logic                           no_pairs,
	output logic                           zero_variance,
	output logic                           overflowed
);

	// Vector state
	logic [CNT_W-1:0]        stored_q, x_cnt_q, y_cnt_q;
	logic signed [SUM_W-1:0] x_sum_q, y_sum_q;
	logic                    ovf_q;
	logic                    store_free;

	// Divider
	logic [CNT_W-1:0]         div_rem_q, divisor;
	logic [NUM_W-1:0]         div_quo_q;
	logic                     div_neg_q, div_zero_q;
	logic signed [SUM_W-1:0]  div_src;
	logic [SUM_W-1:0]         div_mag;
	logic [CNT_W:0]           div_r2;
	logic                     div_ge;
	logic signed [MEAN_W-1:0] div_mean, mean_x_q, mean_y_q;

	// Walk
	logic [CNT_W-1:0]          widx_q;
	logic                      issue, v_s1, v_s2;
	logic [ENTRY_W-1:0]        rd_data;
	logic signed [DIFF_W-1:0]  dx, dy;
	logic signed [PRODS_W-1:0] pxx_s2, pyy_s2, pxy_s2;
	logic [ACC_W-1:0]          xx_q, yy_q, axy;
	logic signed [ACC_W-1:0]   xy_q;
	logic [CNT_W-1:0]          n_q, opp_q;

	// Multiplier and root search
	logic [PROD_W-1:0] mcand_q, macc_q, den_q;
	logic [ACC_W-1:0]  mplier_q;
	logic [ROOT_W-1:0] rem_t_q, term_q;
	logic [QD_W-1:0]   qd_q;
	logic [Q_W-1:0]    q_q, q_mag;
	logic              neg_r, nz, zv;

	mcc_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (cmd.load && store_free),
		.waddr(stored_q[ADDR_W-1:0]),
		.wdata({y_missing, y_sample, x_missing, x_sample}),
		.re   (issue),
		.raddr(widx_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	assign store_free = (stored_q < CNT_W'(DEPTH));

	// Load pairs and accumulate plain sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			x_cnt_q  <= '0;
			y_cnt_q  <= '0;
			x_sum_q  <= '0;
			y_sum_q  <= '0;
			ovf_q    <= 1'b0;
		end else if (cmd.out_load) begin
			stored_q <= '0;
			x_cnt_q  <= '0;
			y_cnt_q  <= '0;
			x_sum_q  <= '0;
			y_sum_q  <= '0;
			ovf_q    <= 1'b0;
		end else if (cmd.load) begin
			if (store_free) begin
				stored_q <= stored_q + CNT_W'(1);
				if (!x_missing) begin
					x_sum_q <= x_sum_q + SUM_W'(x_sample);
					x_cnt_q <= x_cnt_q + CNT_W'(1);
				end
				if (!y_missing) begin
					y_sum_q <= y_sum_q + SUM_W'(y_sample);
					y_cnt_q <= y_cnt_q + CNT_W'(1);
				end
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Rounded mean by restoring division, one quotient bit a cycle
	assign div_src = cmd.div_sel ? y_sum_q : x_sum_q;
	assign divisor = cmd.div_sel ? y_cnt_q : x_cnt_q;
	assign div_mag = div_src[SUM_W-1] ? SUM_W'(-div_src) : SUM_W'(div_src);
	assign div_r2  = {div_rem_q, div_quo_q[NUM_W-1]};
	assign div_ge  = (div_r2 >= {1'b0, divisor});
	assign div_mean = div_zero_q ? '0 :
		div_neg_q ? -$signed(div_quo_q[MEAN_W-1:0]) : $signed(div_quo_q[MEAN_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			div_rem_q  <= '0;
			div_quo_q  <= {1'b0, div_mag} + NUM_W'(divisor >> 1);
			div_neg_q  <= div_src[SUM_W-1];
			div_zero_q <= (divisor == '0);
		end else if (cmd.div_step) begin
			div_rem_q <= div_ge ? CNT_W'(div_r2 - {1'b0, divisor}) : div_r2[CNT_W-1:0];
			div_quo_q <= {div_quo_q[NUM_W-2:0], div_ge};
		end
		if (cmd.div_save) begin
			if (cmd.div_sel) mean_y_q <= div_mean;
			else mean_x_q <= div_mean;
		end
	end

	// Walk the stored pairs: read, center and multiply, accumulate
	assign issue = cmd.walk_run && (widx_q < stored_q);
	assign dx = DIFF_W'($signed(rd_data[SAMPLE_WIDTH-1:0])) - DIFF_W'(mean_x_q);
	assign dy = DIFF_W'($signed(rd_data[2*SAMPLE_WIDTH:SAMPLE_WIDTH+1])) - DIFF_W'(mean_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (cmd.walk_init) widx_q <= '0;
			else if (issue) widx_q <= widx_q + CNT_W'(1);
			v_s1 <= issue;
			v_s2 <= v_s1 && !rd_data[SAMPLE_WIDTH] && !rd_data[ENTRY_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			pxx_s2 <= dx * dx;
			pyy_s2 <= dy * dy;
			pxy_s2 <= dx * dy;
		end
		if (cmd.walk_init) begin
			xx_q  <= '0;
			yy_q  <= '0;
			xy_q  <= '0;
			n_q   <= '0;
			opp_q <= '0;
		end else if (v_s2) begin
			xx_q  <= xx_q + ACC_W'(unsigned'(pxx_s2));
			yy_q  <= yy_q + ACC_W'(unsigned'(pyy_s2));
			xy_q  <= xy_q + ACC_W'(pxy_s2);
			n_q   <= n_q + CNT_W'(1);
			opp_q <= opp_q + CNT_W'(pxy_s2[PRODS_W-1]);
		end
	end

	// Shift-add multiplier for xx*yy and xy*xy
	assign axy = xy_q[ACC_W-1] ? ACC_W'(-xy_q) : ACC_W'(xy_q);

	always_ff @(posedge clk) begin
		if (cmd.mul_init) begin
			macc_q   <= '0;
			mcand_q  <= PROD_W'(cmd.mul_sel ? axy : xx_q);
			mplier_q <= cmd.mul_sel ? axy : yy_q;
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) macc_q <= macc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
		if (cmd.mul_save) begin
			if (cmd.mul_sel) begin
				rem_t_q <= ROOT_W'(macc_q) << FRAC_SHIFT;
				qd_q    <= '0;
				q_q     <= '0;
			end else begin
				den_q <= macc_q;
			end
		end else if (cmd.root_term) begin
			// growth of q^2*den when bit is set
			term_q <= (ROOT_W'(qd_q) << ({1'b0, cmd.root_bit} + (QB_W + 1)'(1)))
				+ (ROOT_W'(den_q) << {cmd.root_bit, 1'b0});
		end else if (cmd.root_cmp) begin
			if (term_q <= rem_t_q) begin
				rem_t_q <= rem_t_q - term_q;
				qd_q    <= qd_q + (QD_W'(den_q) << cmd.root_bit);
				q_q[cmd.root_bit] <= 1'b1;
			end
		end
	end

	// Result register
	assign nz    = (n_q == '0);
	assign zv    = !nz && (xx_q == '0 || yy_q == '0);
	assign q_mag = q_q[Q_W-1] ? {1'b0, {(Q_W-1){1'b1}}} : q_q;
	assign neg_r = ({opp_q, 1'b0} > {1'b0, x_cnt_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			correlation   <= (nz || zv) ? '0 :
				neg_r ? -$signed(q_mag) : $signed(q_mag);
			pair_count    <= n_q;
			no_pairs      <= nz;
			zero_variance <= zv;
			overflowed    <= ovf_q;
		end
	end

	assign sts.walk_done = (widx_q == stored_q) && !v_s1 && !v_s2;
	assign sts.special   = nz || (xx_q == '0) || (yy_q == '0);
	assign sts.out_free  = !out_valid || out_ready;

	assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CNT_W'(DEPTH))
		else $error("store count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (stored_q == '0 && x_cnt_q == '0 && !ovf_q))
		else $error("vector not cleared after result");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (n_q <= stored_q))
		else $error("pair count exceeds stored count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !sts.special) |-> (q_q <= Q_W'(1 << (Q_W - 1))))
		else $error("correlation magnitude above one");

endmodule

// ===== src/masked_correlation_coefficient.sv =====
// Channel | Dir | Transfer fields
// s_*     | in  | tdata: x_sample, y_sample; tuser: x_missing, y_missing; tlast: last_pair
// m_*     | out | tdata: correlation, pair_count; tuser: no_pairs, zero_variance, overflowed
//
// Loading takes one cycle per pair; pairs beyond the store depth are dropped.
// After a last pair: two mean divisions (one quotient bit a cycle), a walk over
// the pair RAM read port (setup, one read per pair, two pipe stages and the
// drain check), a check state, two shift-add multiplies and a root search (a
// term and a compare step per result bit). Special cases skip the multiplies and root.
// Reset clears the vector counts and sums at once; the RAM needs no clearing.
// The result waits in an output register; a stalled receiver stalls only the
// finish step, after which loading restarts.
module masked_correlation_coefficient
	import mcc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // x_sample, y_sample
	input  logic [1:0]           s_tuser,  // x_missing, y_missing
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // correlation, pair_count
	output logic [2:0]           m_tuser   // no_pairs, zero_variance, overflowed
);

	cmd_t                    cmd;
	sts_t                    sts;
	logic signed [CORR_W-1:0] correlation;
	logic [CNT_W-1:0]        pair_count;
	logic                    no_pairs, zero_variance, overflowed;

	mcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_last (s_tlast),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	mcc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.x_sample     (s_tdata[SAMPLE_WIDTH-1:0]),
		.x_missing    (s_tuser[0]),
		.y_sample     (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
		.y_missing    (s_tuser[1]),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.correlation  (correlation),
		.pair_count   (pair_count),
		.no_pairs     (no_pairs),
		.zero_variance(zero_variance),
		.overflowed   (overflowed)
	);

	// Pack the result transfer
	assign m_tdata = {{(M_TDATA_W - CORR_W - CNT_W){1'b0}}, pair_count, correlation};
	assign m_tuser = {overflowed, zero_variance, no_pairs};

endmodule

// ===== tb/masked_correlation_coefficient_tb.sv =====
module masked_correlation_coefficient_tb
	import mcc_pkg::*;
();

	typedef struct {
		logic signed [15:0] x;
		logic               xm;
		logic signed [15:0] y;
		logic               ym;
		logic               last;
		logic               hold;   // wait for all results before offering
	} pair_t;

	typedef struct {
		logic signed [15:0] corr;
		logic [10:0]        cnt;
		logic               no_pairs;
		logic               zero_var;
		logic               ovf;
	} corr_result_t;

	localparam int QUIET_START = 20000;
	localparam int QUIET_END   = 32000;
	localparam int STALL_LEN   = 3000;
	localparam int WATCHDOG    = 20000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [2:0]           m_tuser;

	pair_t        pending_pairs[$];
	pair_t        current_pair;
	corr_result_t expected_results[$];

	// Predictor state for the vector being loaded
	pair_t              vector_store[$];
	longint             x_sum, y_sum;
	int                 x_present, y_present;
	logic               dropped;

	int cycle_count = 0, idle_count = 0, errors = 0;
	int results_seen = 0, vectors_sent = 0, overflow_vectors = 0, special_seen = 0;
	int stall_left = 0;
	bit stall_done = 0;

	masked_correlation_coefficient u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint mean_of(longint sum, int n);
		longint mag;
		if (n == 0)
			return 0;
		mag = (sum < 0) ? -sum : sum;
		mag = (mag + n / 2) / n;
		return (sum < 0) ? -mag : mag;
	endfunction

	// Load one pair into the predictor; on a last pair queue the expected result
	function automatic void absorb_pair(pair_t p);
		longint m1, m2, d1, d2, prod, xx, yy, xy, axy;
		logic [159:0] den, num, c;
		int n, opp, q;
		corr_result_t r;
		if (vector_store.size() < DEPTH) begin
			vector_store.push_back(p);
			if (!p.xm) begin x_sum += p.x; x_present++; end
			if (!p.ym) begin y_sum += p.y; y_present++; end
		end else begin
			dropped = 1'b1;
		end
		if (!p.last)
			return;
		m1 = mean_of(x_sum, x_present);
		m2 = mean_of(y_sum, y_present);
		xx = 0; yy = 0; xy = 0; n = 0; opp = 0; q = 0;
		foreach (vector_store[i]) begin
			if (!vector_store[i].xm && !vector_store[i].ym) begin
				n++;
				d1 = longint'(vector_store[i].x) - m1;
				d2 = longint'(vector_store[i].y) - m2;
				prod = d1 * d2;
				xx += d1 * d1;
				yy += d2 * d2;
				xy += prod;
				if (prod < 0)
					opp++;
			end
		end
		r.cnt = n[10:0];
		r.no_pairs = (n == 0);
		r.zero_var = (n != 0) && (xx == 0 || yy == 0);
		r.ovf = dropped;
		if (n != 0 && xx != 0 && yy != 0) begin
			axy = (xy < 0) ? -xy : xy;
			den = 160'(xx) * 160'(yy);
			num = (160'(axy) * 160'(axy)) << 30;
			for (int b = 15; b >= 0; b--) begin
				c = 160'(q | (1 << b));
				if (c * c * den <= num)
					q = q | (1 << b);
			end
			if (q > 32767)
				q = 32767;
			if (2 * opp > x_present)
				q = -q;
		end
		r.corr = q[15:0];
		if (r.no_pairs || r.zero_var)
			special_seen++;
		if (dropped)
			overflow_vectors++;
		expected_results.push_back(r);
		vector_store.delete();
		x_sum = 0; y_sum = 0; x_present = 0; y_present = 0; dropped = 1'b0;
	endfunction

	function automatic bit idle_draw();
		if (cycle_count >= QUIET_START && cycle_count < QUIET_END)
			return 0;
		return $urandom_range(99) < 36;
	endfunction

	// Sender: account for the transfer, then offer the next pair or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (s_tvalid && s_tready) begin
				absorb_pair(current_pair);
				if (current_pair.last)
					vectors_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_pairs.size() > 0 && !idle_draw() &&
						!(pending_pairs[0].hold && expected_results.size() > 0)) begin
					current_pair = pending_pairs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {current_pair.y, current_pair.x};
					s_tuser <= {current_pair.ym, current_pair.xm};
					s_tlast <= current_pair.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random backpressure plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if (!stall_done && results_seen == 6) begin
				stall_done <= 1;
				stall_left <= STALL_LEN;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !idle_draw();
			end
		end
	end

	// Monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result tdata=%h tuser=%b", $time, m_tdata, m_tuser);
			end else begin
				corr_result_t e;
				e = expected_results.pop_front();
				if (m_tdata[15:0] !== e.corr || m_tdata[26:16] !== e.cnt ||
						m_tdata[M_TDATA_W-1:27] !== '0 ||
						m_tuser !== {e.ovf, e.zero_var, e.no_pairs}) begin
					errors++;
					$display("%0t: mismatch expected corr=%0d cnt=%0d flags=%b%b%b",
						$time, e.corr, e.cnt, e.ovf, e.zero_var, e.no_pairs);
					$display("%0t:          actual   corr=%0d cnt=%0d flags=%b",
						$time, $signed(m_tdata[15:0]), m_tdata[26:16], m_tuser);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count > WATCHDOG) begin
			$display("timeout at %0t", $time);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic void add_pair(int x, bit xm, int y, bit ym, bit last, bit hold = 0);
		pair_t p;
		p.x = x[15:0]; p.xm = xm; p.y = y[15:0]; p.ym = ym; p.last = last; p.hold = hold;
		pending_pairs.push_back(p);
	endfunction

	function automatic int rand_sample();
		return int'($signed(16'($urandom())));
	endfunction

	// Random vector: mostly correlated content with some missing entries
	function automatic void add_vector(int len, bit hold = 0);
		int slope, x, y, mode;
		mode = $urandom_range(9);
		slope = $urandom_range(6) - 3;
		for (int i = 0; i < len; i++) begin
			if (mode < 2) begin
				x = rand_sample();
				y = rand_sample();
			end else begin
				x = $urandom_range(8000) - 4000;
				y = slope * x + $urandom_range(2000) - 1000;
				if (mode == 9)
					y = 1234;
			end
			add_pair(x, $urandom_range(6) == 0, y, $urandom_range(6) == 0,
				i == len - 1, hold && i == 0);
		end
	endfunction

	initial begin
		x_sum = 0; y_sum = 0; x_present = 0; y_present = 0; dropped = 1'b0;
		// Directed: extremes, single pair, all missing, constant, perfect and inverse
		add_pair(-32768, 0, 32767, 0, 0);
		add_pair(32767, 0, -32768, 0, 1);
		add_pair(100, 0, 200, 0, 1);
		add_pair(5, 1, 6, 0, 0);
		add_pair(7, 0, 8, 1, 1);
		add_pair(500, 0, 1, 0, 0);
		add_pair(500, 0, 2, 0, 0);
		add_pair(500, 0, 3, 0, 1);
		for (int i = 0; i < 5; i++)
			add_pair(i * 300, 0, i * 600 - 7, 0, i == 4);
		for (int i = 0; i < 5; i++)
			add_pair(i * 300 - 1, 0, 1000 - i * 250, 0, i == 4);
		add_pair(-1, 0, -1, 0, 0);
		add_pair(32767, 0, 32767, 0, 0);
		add_pair(-32768, 1, -32768, 1, 1, 1);
		// Random vectors, one of them past the store depth with last on a dropped pair
		for (int v = 0; v < 40; v++)
			add_vector($urandom_range(12, 1), v % 20 == 10);
		add_vector(DEPTH + 6);
		for (int v = 0; v < 20; v++)
			add_vector($urandom_range(12, 1));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_pairs.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d vectors, %0d results, %0d special, %0d with dropped pairs",
			vectors_sent, results_seen, special_seen, overflow_vectors);
		if (errors == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
src/mcc_pkg.sv
src/mcc_ram.sv
src/mcc_ctrl.sv
src/mcc_dp.sv
src/masked_correlation_coefficient.sv
tb/masked_correlation_coefficient_tb.sv
